@@ rtl/core/gww_pkg.sv @@
// Shared constants, types and register codes for the word-wrap line breaker.
package gww_pkg;

   localparam int INDEX_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH        = 4;

   localparam logic [20:0] NL_CODE    = 21'd10;
   localparam logic [20:0] SPACE_CODE = 21'd32;
   localparam logic [20:0] CTRL_LIMIT = 21'd32;

   localparam logic [30:0] WRAP_WIDTH_RESET = 31'h7FFF_FFFF;
   localparam logic [15:0] SCALE_X_RESET    = 16'd256;
   localparam logic signed [31:0] POS_MAX   = 32'sh7FFF_FFFF;

   typedef enum logic {
      REG_WRAP_WIDTH = 1'b0,
      REG_SCALE_X    = 1'b1
   } reg_index_type;

   // Item held in the input register, with the glyph width already scaled to Q19.12.
   typedef struct packed {
      logic [20:0]        codepoint;
      logic signed [31:0] pen_x;
      logic [30:0]        scaled_width;
      logic               last_glyph;
   } item_type;

   typedef struct packed {
      logic [31:0] line_start;
      logic [31:0] line_count;
      logic        is_last;
   } rsp_item_type;

   // Up to two results produced by one item, in order.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type res0;
      rsp_item_type res1;
   } push_type;

endpackage

@@ rtl/core/gww_if.sv @@
// Handshake channels for glyph items and line results.
interface gww_req_if;
   logic               valid;
   logic               ready;
   logic [20:0]        codepoint;
   logic signed [31:0] pen_x;
   logic [10:0]        glyph_width;
   logic               last_glyph;

   modport source (output valid, codepoint, pen_x, glyph_width, last_glyph, input ready);
   modport sink   (input valid, codepoint, pen_x, glyph_width, last_glyph, output ready);
endinterface

interface gww_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] line_start;
   logic [31:0] line_count;
   logic        is_last;

   modport source (output valid, line_start, line_count, is_last, input ready);
   modport sink   (input valid, line_start, line_count, is_last, output ready);
endinterface

@@ rtl/core/gww_csr.sv @@
// Configuration registers behind the APB-style port.
module gww_csr
   import gww_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [30:0] wrap_width,
   output logic [15:0] scale_x
);

   logic [30:0]   wrap_width_ff, wrap_width_in;
   logic [15:0]   scale_x_ff, scale_x_in;
   logic          write_en;
   reg_index_type reg_sel;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite && pready;
   assign reg_sel  = reg_index_type'(paddr[2]);

   always_comb begin
      wrap_width_in = wrap_width_ff;
      scale_x_in    = scale_x_ff;
      if (write_en) begin
         unique case (reg_sel)
            REG_WRAP_WIDTH: wrap_width_in = pwdata[30:0];
            REG_SCALE_X:    scale_x_in    = pwdata[15:0];
            default:        wrap_width_in = wrap_width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_WRAP_WIDTH: prdata = {1'b0, wrap_width_ff};
         REG_SCALE_X:    prdata = {16'd0, scale_x_ff};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_width_ff <= WRAP_WIDTH_RESET;
         scale_x_ff    <= SCALE_X_RESET;
      end else begin
         wrap_width_ff <= wrap_width_in;
         scale_x_ff    <= scale_x_in;
      end
   end

   assign wrap_width = wrap_width_ff;
   assign scale_x    = scale_x_ff;

endmodule

@@ rtl/core/gww_in_stage.sv @@
// Input register: takes a glyph item and scales its width on the way in.
module gww_in_stage
   import gww_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   gww_req_if.sink     req_if,
   input  logic [15:0] scale_x,
   output item_type    item,
   output logic        item_valid,
   input  logic        item_take
);

   logic        valid_ff, valid_in;
   item_type    item_ff, item_in;
   logic [26:0] product;
   logic        accept;

   assign req_if.ready = !valid_ff || item_take;
   assign accept       = req_if.valid && req_if.ready;
   assign product      = 27'(req_if.glyph_width) * 27'(scale_x);

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in             = 1'b1;
         item_in.codepoint    = req_if.codepoint;
         item_in.pen_x        = req_if.pen_x;
         item_in.scaled_width = {product, 4'd0};
         item_in.last_glyph   = req_if.last_glyph;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

@@ rtl/core/gww_core.sv @@
// Line-break decision and line tracking state.
module gww_core
   import gww_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  item_type    item,
   input  logic        item_valid,
   output logic        item_take,
   input  logic        room,
   input  logic [30:0] wrap_width,
   output push_type    push
);

   typedef logic [INDEX_BITS-1:0] index_type;

   index_type          glyph_index_ff, glyph_index_in;
   index_type          line_start_index_ff, line_start_index_in;
   index_type          after_space_index_ff, after_space_index_in;
   index_type          pending_count_ff, pending_count_in;
   logic signed [31:0] line_start_pos_ff, line_start_pos_in;
   logic signed [31:0] space_pos_ff, space_pos_in;

   logic               is_nl, is_space, is_ctrl;
   logic signed [32:0] right_sum;
   logic signed [31:0] right_edge;
   logic signed [32:0] span;
   logic               too_wide, do_break, at_space;
   logic signed [31:0] space_pos_new;
   index_type          brk, brk_next, glyph_next;

   function automatic logic [31:0] to_out(index_type v);
      logic [INDEX_BITS+31:0] w;
      w = {32'd0, v};
      return w[31:0];
   endfunction

   assign item_take = item_valid && room;

   assign is_nl    = item.codepoint == NL_CODE;
   assign is_space = item.codepoint == SPACE_CODE;
   assign is_ctrl  = (item.codepoint < CTRL_LIMIT) && !is_nl;

   // Saturate only at the top: the scaled width is never negative.
   assign right_sum  = {item.pen_x[31], item.pen_x} + $signed({2'b00, item.scaled_width});
   assign right_edge = (!right_sum[32] && right_sum[31]) ? POS_MAX : right_sum[31:0];
   assign span       = {right_edge[31], right_edge} - {line_start_pos_ff[31], line_start_pos_ff};
   assign too_wide   = !span[32] && (span[31:0] > {1'b0, wrap_width});
   assign do_break   = (!is_space && too_wide) || is_nl;
   assign at_space   = (after_space_index_ff > line_start_index_ff) && !is_nl;

   assign space_pos_new = (after_space_index_ff == glyph_index_ff) ? item.pen_x : space_pos_ff;
   assign brk           = at_space ? after_space_index_ff : glyph_index_ff;
   assign brk_next      = is_nl ? index_type'(brk + 1'b1) : brk;
   assign glyph_next    = index_type'(glyph_index_ff + 1'b1);

   always_comb begin
      glyph_index_in       = glyph_index_ff;
      line_start_index_in  = line_start_index_ff;
      after_space_index_in = after_space_index_ff;
      pending_count_in     = pending_count_ff;
      line_start_pos_in    = line_start_pos_ff;
      space_pos_in         = space_pos_ff;
      push                 = '0;
      if (item_take) begin
         if (is_ctrl) begin
            glyph_index_in   = glyph_next;
            pending_count_in = index_type'(pending_count_ff + 1'b1);
         end else begin
            space_pos_in   = space_pos_new;
            glyph_index_in = glyph_next;
            if (do_break) begin
               push.count           = 2'd1;
               push.res0.line_start = to_out(line_start_index_ff);
               push.res0.line_count = to_out(index_type'(brk - line_start_index_ff));
               line_start_index_in  = brk_next;
               pending_count_in     = index_type'(glyph_next - brk_next);
               line_start_pos_in    = at_space ? space_pos_new : item.pen_x;
            end else begin
               pending_count_in = index_type'(pending_count_ff + 1'b1);
               if (is_space) begin
                  after_space_index_in = glyph_next;
               end
            end
         end
         // Flush the pending line if it is not empty, tag the final result and start a new run.
         if (item.last_glyph) begin
            if (pending_count_in != '0) begin
               if (push.count == 2'd0) begin
                  push.res0.line_start = to_out(line_start_index_in);
                  push.res0.line_count = to_out(pending_count_in);
                  push.count           = 2'd1;
               end else begin
                  push.res1.line_start = to_out(line_start_index_in);
                  push.res1.line_count = to_out(pending_count_in);
                  push.count           = 2'd2;
               end
            end
            if (push.count == 2'd2) begin
               push.res1.is_last = 1'b1;
            end else begin
               push.res0.is_last = 1'b1;
            end
            glyph_index_in       = '0;
            line_start_index_in  = '0;
            after_space_index_in = '0;
            pending_count_in     = '0;
            line_start_pos_in    = '0;
            space_pos_in         = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_index_ff       <= '0;
         line_start_index_ff  <= '0;
         after_space_index_ff <= '0;
         pending_count_ff     <= '0;
         line_start_pos_ff    <= '0;
         space_pos_ff         <= '0;
      end else begin
         glyph_index_ff       <= glyph_index_in;
         line_start_index_ff  <= line_start_index_in;
         after_space_index_ff <= after_space_index_in;
         pending_count_ff     <= pending_count_in;
         line_start_pos_ff    <= line_start_pos_in;
         space_pos_ff         <= space_pos_in;
      end
   end

   a_pending_tracks_index: assert property (@(posedge clock) disable iff (reset)
      pending_count_ff == index_type'(glyph_index_ff - line_start_index_ff))
      else $error("pending count out of step with glyph and line start indices");

   a_last_clears_run: assert property (@(posedge clock) disable iff (reset)
      item_take && item.last_glyph |=> glyph_index_ff == '0 && line_start_index_ff == '0)
      else $error("run state not cleared after final glyph");

   a_two_only_on_last: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> item_take && item.last_glyph && push.res1.is_last)
      else $error("two results from an item that is not the final glyph");

endmodule

@@ rtl/core/gww_out_queue.sv @@
// Result queue: takes up to two results a cycle while it has room, hands out one when ready.
module gww_out_queue
   import gww_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   gww_rsp_if.source rsp_if
);

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   rsp_item_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0]   wr_ptr_next;
   logic                  pop;

   assign pop         = rsp_if.valid && rsp_if.ready;
   assign room        = count_ff <= COUNT_BITS'(QUEUE_DEPTH - 2);
   assign wr_ptr_next = PTR_BITS'(wr_ptr_ff + 1'b1);

   always_comb begin
      wr_ptr_in = PTR_BITS'(wr_ptr_ff + PTR_BITS'(push.count));
      rd_ptr_in = pop ? PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = COUNT_BITS'(count_ff + COUNT_BITS'(push.count) - COUNT_BITS'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_next] <= push.res1;
      end
   end

   assign rsp_if.valid      = count_ff != '0;
   assign rsp_if.line_start = entries_ff[rd_ptr_ff].line_start;
   assign rsp_if.line_count = entries_ff[rd_ptr_ff].line_count;
   assign rsp_if.is_last    = entries_ff[rd_ptr_ff].is_last;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= COUNT_BITS'(QUEUE_DEPTH - 2))
      else $error("results pushed without room in the queue");

   a_push_shows_result: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |=> rsp_if.valid)
      else $error("pushed result not presented");

endmodule

@@ rtl/core/greedy_word_wrap_breaker_unit.sv @@
// Greedy word-wrap line breaker: top level.
// Each glyph item is registered in the input stage, and its results in the result queue.
// Throughput: one glyph item per cycle while the result queue has room; an item that breaks
// a line and flushes it yields two results, which leave the result port one at a time.
// The four-entry result queue sets how far the input runs ahead of a stalled output.
// Reset (synchronous): run state zeroed, queue emptied, wrap_width and scale_x to defaults.
module greedy_word_wrap_breaker_unit
   import gww_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   gww_req_if.sink     req_if,
   gww_rsp_if.source   rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [30:0] wrap_width;
   logic [15:0] scale_x;
   item_type    item;
   logic        item_valid;
   logic        item_take;
   logic        room;
   push_type    push;

   gww_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .wrap_width (wrap_width),
      .scale_x    (scale_x)
   );

   gww_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .scale_x    (scale_x),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take)
   );

   gww_core #(
      .INDEX_BITS (INDEX_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .room       (room),
      .wrap_width (wrap_width),
      .push       (push)
   );

   gww_out_queue u_out_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_if (rsp_if)
   );

endmodule
